// ===== rtl/pulse_high_low_duty_meter_core_macros.svh =====
// Assertion macros shared by the pulse duty meter RTL.
`ifndef PULSE_HIGH_LOW_DUTY_METER_CORE_MACROS_SVH
`define PULSE_HIGH_LOW_DUTY_METER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PWDM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PWDM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pwdm_pkg.sv =====
// Package with the microcode table, operand widths and register codes of the duty meter.
package pwdm_pkg;

	localparam int NUM_W = 27;
	localparam int SUM_W = 17;
	localparam int PC_W  = 3;

	localparam logic REG_PRESCALE = 1'b0;
	localparam logic REG_CLOCK    = 1'b1;

	localparam logic [1:0] SRC_NONE   = 2'd0;
	localparam logic [1:0] SRC_PERIOD = 2'd1;
	localparam logic [1:0] SRC_DUTY   = 2'd2;
	localparam logic [1:0] SRC_FREQ   = 2'd3;

	localparam logic [PC_W-1:0] STEP_ACCEPT = 3'd0;
	localparam logic [PC_W-1:0] STEP_EMIT   = 3'd7;

	localparam logic [19:0] HZ_PER_MHZ = 20'd1000000;
	localparam logic [6:0]  PERCENT    = 7'd100;

	typedef struct packed {
		logic            accept;
		logic [1:0]      load;
		logic            wait_div;
		logic [1:0]      latch;
		logic            emit;
		logic            skip_nosig;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t cw;
		cw = '{accept: 1'b0, load: SRC_NONE, wait_div: 1'b0, latch: SRC_NONE,
			emit: 1'b0, skip_nosig: 1'b0, target: STEP_ACCEPT};
		case (pc)
			3'd0: cw.accept = 1'b1;
			3'd1: begin
				cw.load       = SRC_PERIOD;
				cw.skip_nosig = 1'b1;
				cw.target     = STEP_EMIT;
			end
			3'd2: begin
				cw.wait_div = 1'b1;
				cw.latch    = SRC_PERIOD;
			end
			3'd3: cw.load = SRC_DUTY;
			3'd4: begin
				cw.wait_div = 1'b1;
				cw.latch    = SRC_DUTY;
			end
			3'd5: cw.load = SRC_FREQ;
			3'd6: begin
				cw.wait_div = 1'b1;
				cw.latch    = SRC_FREQ;
			end
			3'd7: cw.emit = 1'b1;
			default: cw.accept = 1'b1;
		endcase
		return cw;
	endfunction

	function automatic logic [3:0] pre_shift(input logic [2:0] sel);
		logic [3:0] sh;
		case (sel)
			3'd0, 3'd1: sh = 4'd0;
			3'd2: sh = 4'd3;
			3'd3: sh = 4'd6;
			3'd4: sh = 4'd8;
			default: sh = 4'd10;
		endcase
		return sh;
	endfunction

endpackage

// ===== rtl/pwdm_div.sv =====
// Restoring unsigned divider that retires one quotient bit per cycle.
module pwdm_div
	import pwdm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [NUM_W-1:0] den_q;
	logic [NUM_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= NUM_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[NUM_W-1:0];
			end
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

// ===== rtl/pulse_high_low_duty_meter_core.sv =====
// Top level of the pulse duty meter: microcode sequencer, datapath and stream ports.
// One capture is accepted, then three divisions run through one shared divider; when
// high plus low is zero the divisions are skipped and the result is emitted directly.
// The next capture is taken only after the previous result is loaded for output, which
// waits while the result before it is still not taken. The divider sets the pace.
// Reset clears the stored times, arms the rising edge and sets prescale 1 and 8 MHz.
`include "pulse_high_low_duty_meter_core_macros.svh"

module pulse_high_low_duty_meter_core
	import pwdm_pkg::*;
#(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // capture_value
	output logic        m_tvalid,
	input  logic        m_tready,
	// high_time, low_time, period_us, duty_percent, frequency_hz, one zero pad bit
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser   // next_edge_rising, no_signal
);

	localparam int SW = (COUNTER_WIDTH < 16) ? COUNTER_WIDTH : 16;

	logic [2:0]      prescale_q;
	logic [5:0]      clock_q;
	logic [PC_W-1:0] pc_q;
	logic            awaiting_q;
	logic [SW-1:0]   high_q;
	logic [SW-1:0]   low_q;
	logic [15:0]     period_q;
	logic [6:0]      duty_q;
	logic [15:0]     freq_q;
	logic            out_valid_q;
	logic [71:0]     out_data_q;
	logic [1:0]      out_user_q;

	ctrl_word_t       cw;
	logic [SUM_W-1:0] sum;
	logic             nosig;
	logic [3:0]       shift;
	logic             stall;
	logic             take_skip;
	logic             div_start;
	logic             div_busy;
	logic [NUM_W-1:0] div_num;
	logic [NUM_W-1:0] div_den;
	logic [NUM_W-1:0] div_quot;
	logic [15:0]      quot_sat;
	logic             latch_en;
	logic             load_out;
	logic             accept_in;

	assign cw        = ucode(pc_q);
	assign sum       = SUM_W'(high_q) + SUM_W'(low_q);
	assign nosig     = (sum == '0);
	assign shift     = pre_shift(prescale_q);
	assign accept_in = s_tvalid && cw.accept;
	assign load_out  = cw.emit && (!out_valid_q || m_tready);
	assign take_skip = cw.skip_nosig && nosig;
	assign div_start = (cw.load != SRC_NONE) && !take_skip;
	assign latch_en  = cw.wait_div && !div_busy;
	assign quot_sat  = (|div_quot[NUM_W-1:16]) ? 16'hFFFF : div_quot[15:0];
	assign stall     = (cw.accept && !s_tvalid) || (cw.wait_div && div_busy) ||
		(cw.emit && !load_out);

	always_comb begin
		case (cw.load)
			SRC_PERIOD: begin
				div_num = NUM_W'(sum) << shift;
				div_den = NUM_W'(clock_q);
			end
			SRC_DUTY: begin
				div_num = NUM_W'(high_q) * NUM_W'(PERCENT);
				div_den = NUM_W'(sum);
			end
			SRC_FREQ: begin
				div_num = NUM_W'(clock_q) * NUM_W'(HZ_PER_MHZ);
				div_den = NUM_W'(sum) << shift;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	pwdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= 3'd1;
			clock_q     <= 6'd8;
			pc_q        <= STEP_ACCEPT;
			awaiting_q  <= 1'b0;
			high_q      <= '0;
			low_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_PRESCALE) begin
				prescale_q <= cfg_data[2:0];
			end
			if (cfg_we && cfg_index == REG_CLOCK) begin
				clock_q <= cfg_data;
			end
			if (!stall) begin
				pc_q <= take_skip ? cw.target : PC_W'(pc_q + 1'b1);
			end
			if (accept_in) begin
				awaiting_q <= !awaiting_q;
				if (awaiting_q) begin
					high_q <= s_tdata[SW-1:0];
				end else begin
					low_q <= s_tdata[SW-1:0];
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (latch_en) begin
			case (cw.latch)
				SRC_PERIOD: period_q <= quot_sat;
				SRC_DUTY:   duty_q   <= div_quot[6:0];
				SRC_FREQ:   freq_q   <= quot_sat;
				default:    period_q <= period_q;
			endcase
		end
		if (load_out) begin
			out_data_q <= {1'b0,
				nosig ? 16'd0 : freq_q,
				nosig ? 7'd0 : duty_q,
				nosig ? 16'd0 : period_q,
				16'(low_q),
				16'(high_q)};
			out_user_q <= {nosig, !awaiting_q};
		end
	end

	assign s_tready = cw.accept;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	`PWDM_ASSERT_NOW(a_start_idle, div_start, !div_busy, "divider started while busy")
	`PWDM_ASSERT_NOW(a_emit_free, load_out, !out_valid_q || m_tready, "result overwritten")
	`PWDM_ASSERT_NEXT(a_edge_toggle, accept_in, awaiting_q != $past(awaiting_q), "edge not toggled")
	`PWDM_ASSERT_NOW(a_nosig_zero, m_tvalid && m_tuser[1],
		m_tdata[70:32] == '0, "no signal result carries nonzero derived values")

endmodule
